// ===== design/clcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package clcd_pkg;

  // Expander byte layout
  localparam int unsigned BitRs = 0;
  localparam int unsigned BitRw = 1;
  localparam int unsigned BitEn = 2;
  localparam int unsigned BitBl = 3;

  // Command bits, highest set bit selects the command
  localparam int unsigned CmdSetAddr   = 7;
  localparam int unsigned CmdCgAddr    = 6;
  localparam int unsigned CmdEntryMode = 2;
  localparam int unsigned CmdHome      = 1;
  localparam int unsigned CmdClear     = 0;
  localparam logic [7:0]  CmdNoEffectMask = 8'h38;

  // Display address map
  localparam logic [6:0] AddrWrapLimit  = 7'h68;
  localparam logic [6:0] AddrGapLow     = 7'h28;
  localparam logic [6:0] AddrSecondLine = 7'h40;
  localparam logic [5:0] FoldColumn     = 6'd20;
  localparam logic [2:0] FoldRows       = 3'd4;
  localparam logic [2:0] RowsReset      = 3'd2;
  localparam logic [5:0] ColumnCount    = 6'd16;

  typedef struct packed {
    logic       sel_data;
    logic       have_hi;
    logic [3:0] hi_nib;
    logic [6:0] addr;
    logic       backlight;
  } clcd_state_t;

  typedef struct packed {
    logic       backlight_on;
    logic       text_write;
    logic [1:0] text_row;
    logic [5:0] text_column;
    logic [7:0] text_char;
    logic       clear_text;
  } clcd_result_t;

  localparam clcd_state_t StateReset = '{
    sel_data: 1'b0, have_hi: 1'b0, hi_nib: 4'd0, addr: 7'd0, backlight: 1'b0
  };

endpackage
`default_nettype wire

// ===== design/clcd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
module clcd_decode (
  input  clcd_pkg::clcd_state_t  state_i,
  input  logic [7:0]             port_byte_i,
  input  logic [2:0]             rows_i,
  output clcd_pkg::clcd_state_t  state_o,
  output clcd_pkg::clcd_result_t result_o
);
  import clcd_pkg::*;

  logic       strobe;
  logic       rs;
  logic [7:0] full_byte;
  logic [6:0] addr_fix;
  logic [5:0] col;
  logic [1:0] row;

  always_comb begin
    strobe    = port_byte_i[BitEn] & ~port_byte_i[BitRw];
    rs        = port_byte_i[BitRs];
    full_byte = {state_i.hi_nib, port_byte_i[7:4]};

    // fold the address into the two-line map
    addr_fix = state_i.addr;
    if (addr_fix >= AddrWrapLimit) addr_fix = 7'd0;
    if (addr_fix >= AddrGapLow && addr_fix < AddrSecondLine) addr_fix = AddrSecondLine;
    col = addr_fix[5:0];
    row = {1'b0, addr_fix[6]};
    if (rows_i == FoldRows && col >= FoldColumn) begin
      col = col - FoldColumn;
      row = row + 2'd2;
    end

    state_o  = state_i;
    result_o = '0;

    if (strobe) begin
      state_o.backlight = port_byte_i[BitBl];
      state_o.sel_data  = rs;
      // a register select change drops any half-collected byte
      if (rs != state_i.sel_data || !state_i.have_hi) begin
        state_o.have_hi = 1'b1;
        state_o.hi_nib  = port_byte_i[7:4];
      end else begin
        state_o.have_hi = 1'b0;
        if (rs) begin
          result_o.text_write  = 1'b1;
          result_o.text_row    = row;
          result_o.text_column = col;
          result_o.text_char   = full_byte;
          state_o.addr         = addr_fix + 7'd1;
        end else if (full_byte[CmdSetAddr]) begin
          state_o.addr = full_byte[6:0];
        end else if (full_byte[CmdCgAddr]) begin
          state_o.addr = state_i.addr;
        end else if ((full_byte & CmdNoEffectMask) != 8'd0) begin
          state_o.addr = state_i.addr;
        end else if (full_byte[CmdEntryMode]) begin
          state_o.addr = state_i.addr;
        end else if (full_byte[CmdHome]) begin
          state_o.addr = 7'd0;
        end else if (full_byte[CmdClear]) begin
          state_o.addr         = 7'd0;
          result_o.clear_text  = 1'b1;
        end
      end
    end

    result_o.backlight_on = state_o.backlight;
  end

endmodule
`default_nettype wire

// ===== design/char_lcd_nibble_bus_emulator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | in_port_byte
// out_     | output    | out_valid/out_stall| backlight, text cell write, clear, columns
// cfg_     | input     | cfg_write_en       | cfg_write_data (display rows)
//
// One byte per cycle while in_stall is low: decode is one combinational pass from the
// state registers into the result register, seen in the cycle after acceptance.
// in_stall is high only while a result sits in the result register and
// out_stall holds it. Reset (synchronous, rst_n low) empties the nibble
// collector, selects the command register, zeroes the address and
// backlight and sets display rows to 2.
module char_lcd_nibble_bus_emulator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_port_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_backlight_on,
  output logic       out_text_write,
  output logic [1:0] out_text_row,
  output logic [5:0] out_text_column,
  output logic [7:0] out_text_char,
  output logic       out_clear_text,
  output logic [5:0] out_columns_in_use,
  input  logic       cfg_write_en,
  input  logic [2:0] cfg_write_data
);
  import clcd_pkg::*;

  clcd_state_t  state_r, state_nxt;
  clcd_result_t result_r, result_nxt;
  logic [2:0]   rows_r;
  logic         out_valid_r, out_valid_nxt;
  logic         in_accept;

  clcd_decode u_decode (
    .state_i     (state_r),
    .port_byte_i (in_port_byte),
    .rows_i      (rows_r),
    .state_o     (state_nxt),
    .result_o    (result_nxt)
  );

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    if (in_accept) out_valid_nxt = 1'b1;
    else if (out_stall) out_valid_nxt = out_valid_r;
    else out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StateReset;
      rows_r      <= RowsReset;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) state_r <= state_nxt;
      if (cfg_write_en) rows_r <= cfg_write_data;
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (in_accept) result_r <= result_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_backlight_on   = result_r.backlight_on;
  assign out_text_write     = result_r.text_write;
  assign out_text_row       = result_r.text_row;
  assign out_text_column    = result_r.text_column;
  assign out_text_char      = result_r.text_char;
  assign out_clear_text     = result_r.clear_text;
  assign out_columns_in_use = ColumnCount;

  a_write_or_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_text_write && out_clear_text))
    else $error("cell write and clear in one beat");

  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_write) |-> (out_text_column < 6'd40))
    else $error("column out of range");

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_text_write) |-> (out_text_char == 8'd0 && out_text_column == 6'd0))
    else $error("cell fields set without a write");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import clcd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 200;

  typedef struct packed {
    logic       bl;
    logic       wr;
    logic [1:0] row;
    logic [5:0] col;
    logic [7:0] chr;
    logic       clr;
    logic [5:0] cols;
  } lcd_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_port_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_backlight_on;
  logic       out_text_write;
  logic [1:0] out_text_row;
  logic [5:0] out_text_column;
  logic [7:0] out_text_char;
  logic       out_clear_text;
  logic [5:0] out_columns_in_use;
  logic       cfg_write_en = 1'b0;
  logic [2:0] cfg_write_data = 3'd0;

  char_lcd_nibble_bus_emulator_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_port_byte      (in_port_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_backlight_on  (out_backlight_on),
    .out_text_write    (out_text_write),
    .out_text_row      (out_text_row),
    .out_text_column   (out_text_column),
    .out_text_char     (out_text_char),
    .out_clear_text    (out_clear_text),
    .out_columns_in_use(out_columns_in_use),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data)
  );

  always #10 clk = ~clk;

  // Shadow of the display controller state
  logic [2:0] lcd_rows;
  logic       lcd_rs;
  logic [8:0] lcd_acc;
  logic [6:0] lcd_addr;
  logic       lcd_bl;
  logic [5:0] lcd_cols;

  lcd_beat_t  pending_beats[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned strobes_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned cell_writes = 0;
  int unsigned clears_seen = 0;
  int unsigned row_settings = 0;
  logic       drive_bl = 1'b0;
  bit         sender_gaps = 1'b1;
  bit         receiver_gaps = 1'b1;
  bit         hold_out = 1'b0;
  int         stall_left = 0;
  lcd_beat_t  got_beat;
  lcd_beat_t  want_beat;

  function automatic lcd_beat_t lcd_predict(input logic [7:0] b);
    lcd_beat_t  r;
    logic [7:0] v;
    logic [5:0] x;
    logic [1:0] y;
    r = '0;
    if (b[BitEn] && !b[BitRw]) begin
      lcd_bl = b[BitBl];
      // drop a half-collected byte when register select flips
      if (b[BitRs] != lcd_rs) begin
        lcd_rs = b[BitRs];
        lcd_acc = 9'd1;
      end
      lcd_acc = {lcd_acc[4:0], b[7:4]};
      if (lcd_acc[8]) begin
        v = lcd_acc[7:0];
        if (lcd_rs) begin
          if (lcd_addr >= AddrWrapLimit) lcd_addr = 7'd0;
          if (lcd_addr >= AddrGapLow && lcd_addr < AddrSecondLine) lcd_addr = AddrSecondLine;
          x = lcd_addr[5:0];
          y = {1'b0, lcd_addr[6]};
          if (lcd_rows == FoldRows && x >= FoldColumn) begin
            x = x - FoldColumn;
            y = y + 2'd2;
          end
          r.wr = 1'b1;
          r.row = y;
          r.col = x;
          r.chr = v;
          lcd_addr = lcd_addr + 7'd1;
          if (x >= lcd_cols) lcd_cols = ColumnCount;
        end else begin
          if (v[CmdSetAddr]) begin
            lcd_addr = v[6:0];
          end else if (v[CmdCgAddr] || (v & CmdNoEffectMask) != 8'h00) begin
            // no visible effect
          end else if (v[CmdEntryMode]) begin
            // direction flag is not modeled
          end else if (v[CmdHome]) begin
            lcd_addr = 7'd0;
          end else if (v[CmdClear]) begin
            r.clr = 1'b1;
            lcd_addr = 7'd0;
          end
        end
        lcd_acc = 9'd1;
      end
    end
    r.bl = lcd_bl;
    r.cols = lcd_cols;
    return r;
  endfunction

  function automatic logic [7:0] strobe(input logic [3:0] nib, input logic rs);
    return {nib, drive_bl, 1'b1, 1'b0, rs};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h want %0h at beat %0d", what, got, want, beats_checked);
    errors++;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_beat = '{out_backlight_on, out_text_write, out_text_row, out_text_column,
                   out_text_char, out_clear_text, out_columns_in_use};
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", int'(got_beat), 0);
      end else begin
        want_beat = pending_beats.pop_front();
        if (got_beat.bl !== want_beat.bl)
          report_mismatch("backlight_on", int'(got_beat.bl), int'(want_beat.bl));
        if (got_beat.wr !== want_beat.wr)
          report_mismatch("text_write", int'(got_beat.wr), int'(want_beat.wr));
        if (got_beat.row !== want_beat.row)
          report_mismatch("text_row", int'(got_beat.row), int'(want_beat.row));
        if (got_beat.col !== want_beat.col)
          report_mismatch("text_column", int'(got_beat.col), int'(want_beat.col));
        if (got_beat.chr !== want_beat.chr)
          report_mismatch("text_char", int'(got_beat.chr), int'(want_beat.chr));
        if (got_beat.clr !== want_beat.clr)
          report_mismatch("clear_text", int'(got_beat.clr), int'(want_beat.clr));
        if (got_beat.cols !== want_beat.cols)
          report_mismatch("columns_in_use", int'(got_beat.cols), int'(want_beat.cols));
        if (want_beat.wr) cell_writes++;
        if (want_beat.clr) clears_seen++;
      end
      beats_checked++;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else if (!receiver_gaps) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL char_lcd_nibble_bus_emulator_unit");
      $finish;
    end
  end

  // Offer one byte; valid stays high after the beat so back-to-back beats never glitch it
  task automatic send_byte(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_port_byte <= b;
    do @(posedge clk); while (in_stall);
    pending_beats.push_back(lcd_predict(b));
    bytes_sent++;
    if (b[BitEn] && !b[BitRw]) strobes_sent++;
  endtask

  task automatic send_pair(input logic rs, input logic [7:0] v);
    send_byte(strobe(v[7:4], rs));
    send_byte(strobe(v[3:0], rs));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_rows(input logic [2:0] rows);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= rows;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    lcd_rows = rows;
    row_settings++;
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned start;
    int unsigned k;
    start = bytes_sent;
    while (bytes_sent - start < n) begin
      if ($urandom_range(0, 15) == 0) drive_bl = ~drive_bl;
      k = $urandom_range(0, 99);
      if (k < 45) send_pair(1'b1, 8'($urandom_range(0, 255)));
      else if (k < 60) send_pair(1'b0, 8'h80 | 8'($urandom_range(0, 127)));
      else if (k < 66) send_pair(1'b0, 8'($urandom_range(1, 3)));
      else if (k < 74) send_pair(1'b0, 8'($urandom_range(0, 127)));
      else if (k < 82) send_byte(strobe(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'hFB);
    drive_bl = 1'b1;
    send_pair(1'b0, 8'h01);
    // last column of the first line, then the gap before the second line
    send_pair(1'b0, 8'hA7);
    send_pair(1'b1, 8'hFF);
    send_pair(1'b1, 8'h00);
    // end of the second line, then the wrap back to the start
    send_pair(1'b0, 8'hE7);
    send_pair(1'b1, 8'h5A);
    send_pair(1'b1, 8'hA5);
    drive_bl = 1'b0;
    // half a command, then register select flips
    send_byte(strobe(4'h8, 1'b0));
    send_pair(1'b1, 8'h41);
    send_pair(1'b0, 8'h00);
    send_pair(1'b0, 8'h06);
    send_pair(1'b0, 8'h02);
  endtask

  task automatic test_fold();
    write_rows(FoldRows);
    send_pair(1'b0, 8'hD4);
    send_pair(1'b1, 8'h33);
    send_pair(1'b0, 8'h93);
    send_pair(1'b1, 8'h44);
  endtask

  task automatic test_row_sweep();
    logic [2:0] rows_list[5] = '{3'd0, 3'd1, 3'd3, 3'd4, 3'd2};
    foreach (rows_list[i]) begin
      write_rows(rows_list[i]);
      random_traffic(300);
    end
  endtask

  task automatic test_backpressure();
    write_rows(FoldRows);
    sender_gaps = 1'b0;
    fork
      begin
        hold_out = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    random_traffic(40);
    sender_gaps = 1'b1;
    wait_drained();
    random_traffic(120);
  endtask

  task automatic test_steady();
    write_rows(3'd0);
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    random_traffic(150);
    write_rows(FoldRows);
    random_traffic(150);
  endtask

  initial begin
    lcd_rows = RowsReset;
    lcd_rs = 1'b0;
    lcd_acc = 9'd1;
    lcd_addr = 7'd0;
    lcd_bl = 1'b0;
    lcd_cols = ColumnCount;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fold();
    test_row_sweep();
    test_backpressure();
    test_steady();
    wait_drained();
    repeat (5) @(posedge clk);
    $display("Covered %0d strobe beats and %0d result beats over %0d row settings,",
             strobes_sent, beats_checked, row_settings);
    $display("with %0d cell writes, %0d clears and a long receiver hold-off.",
             cell_writes, clears_seen);
    if (errors == 0) begin
      $display("PASS char_lcd_nibble_bus_emulator_unit");
    end else begin
      $display("FAIL char_lcd_nibble_bus_emulator_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/clcd_pkg.sv
design/clcd_decode.sv
design/char_lcd_nibble_bus_emulator_unit.sv
dv/tb.sv
